FILE: rtl/address_to_function_range_lookup_defines.svh
// Assertion macros for the function range lookup block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ADDRESS_TO_FUNCTION_RANGE_LOOKUP_DEFINES_SVH
`define ADDRESS_TO_FUNCTION_RANGE_LOOKUP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define AFLR_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication.
`define AFLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define AFLR_ASSERT(lbl, clk, rst, ante, cons)
`define AFLR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/aflr_pkg.sv
// Shared types and constants for the function range lookup block.
// No dependencies; imported by every module of the block.
package aflr_pkg;

   localparam int MAX_SYMBOLS = 1024;
   localparam int IDX_W = $clog2(MAX_SYMBOLS);
   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam int ENTRY_IDX_W = 10;
   localparam int COUNT_REG_W = 11;
   localparam int ADDR_W = 32;
   localparam int TYPE_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [TYPE_W-1:0] FUNC_TYPE = 4'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STR_TABLE_LEN = 1'b1;

   typedef struct packed {
      logic                   command;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [ADDR_W-1:0]      sym_base;
      logic [ADDR_W-1:0]      symbol_size;
      logic [TYPE_W-1:0]      symbol_type;
      logic [ADDR_W-1:0]      name_off;
      logic                   name_is_empty;
      logic [ADDR_W-1:0]      query_address;
   } aflr_req_type;

   typedef struct packed {
      logic                   found;
      logic [ADDR_W-1:0]      func_base;
      logic [ADDR_W-1:0]      func_name_off;
      logic [ENTRY_IDX_W-1:0] match_index;
   } aflr_rsp_type;

   // Table entry as stored: end address and eligibility are folded in at write time.
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic              point;
      logic [ADDR_W-1:0] name_off;
      logic              fn_ok;
   } aflr_entry_type;

   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
      aflr_entry_type   entry;
   } aflr_rd_type;

   typedef struct packed {
      logic              busy;
      logic              found;
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] name_off;
      logic [IDX_W-1:0]  idx;
   } aflr_scan_status_type;

endpackage

FILE: rtl/aflr_table.sv
// Symbol entry memory: one write port, one registered read port.
// Depends on aflr_pkg.
module aflr_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [aflr_pkg::IDX_W-1:0]      wr_addr,
   input  aflr_pkg::aflr_entry_type        wr_entry,
   input  logic                            rd_en,
   input  logic [aflr_pkg::IDX_W-1:0]      rd_addr,
   output aflr_pkg::aflr_rd_type           rd
);
   import aflr_pkg::*;

   aflr_entry_type   mem [MAX_SYMBOLS];
   aflr_entry_type   rd_entry_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   assign rd = '{vld: rd_vld_ff, idx: rd_idx_ff, entry: rd_entry_ff};

endmodule

FILE: rtl/aflr_match.sv
// Compare unit: tests one entry per cycle against the query and keeps the best hit.
// Depends on aflr_pkg and the assertion macro header.
`include "address_to_function_range_lookup_defines.svh"
module aflr_match (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  aflr_pkg::aflr_rd_type             rd,
   input  logic [aflr_pkg::ADDR_W-1:0]       query_addr,
   input  logic [aflr_pkg::ADDR_W-1:0]       str_table_len,
   output aflr_pkg::aflr_scan_status_type    status
);
   import aflr_pkg::*;

   logic              hit;
   logic              m_vld_ff;
   logic [ADDR_W-1:0] m_start_ff;
   logic [ADDR_W-1:0] m_name_ff;
   logic [IDX_W-1:0]  m_idx_ff;
   logic              found_ff;
   logic [ADDR_W-1:0] best_start_ff;
   logic [ADDR_W-1:0] best_name_ff;
   logic [IDX_W-1:0]  best_idx_ff;

   always_comb begin
      hit = rd.vld && rd.entry.fn_ok && (rd.entry.name_off < str_table_len) &&
            (query_addr >= rd.entry.start_addr) &&
            (rd.entry.point ? (query_addr == rd.entry.start_addr)
                            : (query_addr < rd.entry.end_addr));
   end

   // Stage 1: register the hit.
   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= hit;
      end
   end

   always_ff @(posedge clock) begin
      m_start_ff <= rd.entry.start_addr;
      m_name_ff  <= rd.entry.name_off;
      m_idx_ff   <= rd.idx;
   end

   // Stage 2: replace the best only on a strictly larger start, so the earliest index wins ties.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         found_ff      <= 1'b0;
         best_start_ff <= '0;
         best_name_ff  <= '0;
         best_idx_ff   <= '0;
      end else if (m_vld_ff && (!found_ff || (m_start_ff > best_start_ff))) begin
         found_ff      <= 1'b1;
         best_start_ff <= m_start_ff;
         best_name_ff  <= m_name_ff;
         best_idx_ff   <= m_idx_ff;
      end
   end

   assign status = '{busy: m_vld_ff, found: found_ff, start_addr: best_start_ff,
                     name_off: best_name_ff, idx: best_idx_ff};

   `AFLR_ASSERT_NEXT(a_best_grows, clock, reset, found_ff && !clear, best_start_ff >= $past(best_start_ff))
   `AFLR_ASSERT_NEXT(a_found_holds, clock, reset, found_ff && !clear, found_ff)
   `AFLR_ASSERT_NEXT(a_skip_ineligible, clock, reset, rd.vld && !rd.entry.fn_ok, !m_vld_ff)

endmodule

FILE: rtl/address_to_function_range_lookup.sv
// Write item: accepted with no result; the entry is usable by the next lookup.
// Lookup item: one entry read per cycle up to min(entry_count, 1024), then a compare drain
// that also waits for a hit still in the compare stage before the result is loaded.
// One item in flight; the input stalls until the result has been loaded for output, which
// waits while an earlier result is still held by the receiver.
// Synchronous active-high reset clears control and CSRs; table and result data stay unknown.
`include "address_to_function_range_lookup_defines.svh"
module address_to_function_range_lookup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  aflr_pkg::aflr_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output aflr_pkg::aflr_rsp_type               rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [aflr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aflr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import aflr_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_type;

   state_type            state_ff;
   logic [COUNT_REG_W-1:0] entry_count_ff;
   logic [ADDR_W-1:0]    str_table_len_ff;
   logic [CNT_W-1:0]     scan_idx_ff;
   logic [CNT_W-1:0]     limit_ff;
   logic [ADDR_W-1:0]    query_ff;
   logic                 rsp_valid_ff;
   aflr_rsp_type         rsp_data_ff;

   logic                 req_accept;
   logic                 start_lookup;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   aflr_entry_type       wr_entry;
   logic                 rd_en;
   logic [CNT_W-1:0]     limit_in;
   logic                 out_free;
   aflr_rd_type          rd;
   aflr_scan_status_type scan_st;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign start_lookup = req_accept && (req_data.command == CMD_LOOKUP);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr_en = req_accept && (req_data.command == CMD_WRITE) &&
              (32'(req_data.entry_index) < MAX_SYMBOLS);
      wr_addr = IDX_W'(req_data.entry_index);
      wr_entry.start_addr  = req_data.sym_base;
      wr_entry.end_addr    = req_data.sym_base + req_data.symbol_size;
      wr_entry.point       = (req_data.symbol_size == '0);
      wr_entry.name_off    = req_data.name_off;
      wr_entry.fn_ok       = (req_data.symbol_type == FUNC_TYPE) && !req_data.name_is_empty;
      limit_in = (32'(entry_count_ff) > MAX_SYMBOLS) ? CNT_W'(MAX_SYMBOLS)
                                                     : CNT_W'(entry_count_ff);
      rd_en = (state_ff == ST_SCAN) && (scan_idx_ff < limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= '0;
         str_table_len_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:   entry_count_ff   <= csr_data[COUNT_REG_W-1:0];
            CSR_STR_TABLE_LEN: str_table_len_ff <= csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start_lookup) begin
                  scan_idx_ff <= '0;
                  limit_ff    <= limit_in;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_en) begin
                  scan_idx_ff <= scan_idx_ff + CNT_W'(1);
               end else begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // wait for the read and compare stages to empty
               if (!rd.vld && !scan_st.busy) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start_lookup) begin
         query_ff <= req_data.query_address;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff.found         <= scan_st.found;
         rsp_data_ff.func_base     <= scan_st.start_addr;
         rsp_data_ff.func_name_off <= scan_st.name_off;
         rsp_data_ff.match_index   <= ENTRY_IDX_W'(scan_st.idx);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   aflr_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (scan_idx_ff[IDX_W-1:0]),
      .rd       (rd)
   );

   aflr_match u_match (
      .clock         (clock),
      .reset         (reset),
      .clear         (start_lookup),
      .rd            (rd),
      .query_addr    (query_ff),
      .str_table_len (str_table_len_ff),
      .status        (scan_st)
   );

   `AFLR_ASSERT(a_scan_bound, clock, reset, state_ff == ST_SCAN, scan_idx_ff <= limit_ff)
   `AFLR_ASSERT(a_idle_pipe_empty, clock, reset, state_ff == ST_IDLE, !rd.vld && !scan_st.busy)
   `AFLR_ASSERT_NEXT(a_done_loads, clock, reset, (state_ff == ST_DONE) && out_free, rsp_valid_ff)

endmodule

FILE: tb/tb_address_to_function_range_lookup.sv
`timescale 1ns / 100ps
// Self-checking testbench for address_to_function_range_lookup: directed table, then random
// phases over several table settings; results checked against given values or a local predictor.
// Depends on aflr_pkg and the block's RTL only.
module tb_address_to_function_range_lookup;
   import aflr_pkg::*;

   localparam int STALL_LIMIT = 6000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      aflr_req_type req;
      bit           typed;
      aflr_rsp_type want;
      logic [31:0]  count_word;
      logic [31:0]  strtab;
   } plan_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   aflr_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   aflr_rsp_type          rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // local copy of the symbol table and registers
   logic [ADDR_W-1:0]      sym_start   [MAX_SYMBOLS];
   logic [ADDR_W-1:0]      sym_size    [MAX_SYMBOLS];
   logic [TYPE_W-1:0]      sym_type    [MAX_SYMBOLS];
   logic [ADDR_W-1:0]      sym_name    [MAX_SYMBOLS];
   logic                   sym_empty   [MAX_SYMBOLS];
   bit                     sym_written [MAX_SYMBOLS];
   logic [COUNT_REG_W-1:0] cfg_count = '0;
   logic [ADDR_W-1:0]      cfg_strtab = '0;

   aflr_rsp_type pending_results[$];
   plan_row_type script[$];

   logic [ADDR_W-1:0] gen_base = '0;
   logic [ADDR_W-1:0] gen_strtab = '0;
   bit                sender_gaps = 1'b1;
   bit                rsp_gaps = 1'b1;
   int                hold_rsp = 0;
   int                error_count = 0;
   int                n_writes = 0;
   int                n_lookups = 0;
   int                n_hits = 0;
   int                n_misses = 0;
   int                n_settings = 0;
   int                quiet_cycles = 0;

   address_to_function_range_lookup u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic note_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Best containing function: largest start wins, lowest slot on a tie.
   function automatic aflr_rsp_type resolve_address(input logic [ADDR_W-1:0] addr);
      aflr_rsp_type      r;
      int                lim;
      int                best;
      bit                have;
      logic [ADDR_W-1:0] top;
      r = '0;
      best = 0;
      have = 1'b0;
      lim = (cfg_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(cfg_count);
      for (int k = 0; k < lim; k++) begin
         if (sym_type[k] != FUNC_TYPE) continue;
         if (sym_name[k] >= cfg_strtab) continue;
         if (sym_empty[k]) continue;
         if (addr < sym_start[k]) continue;
         if (sym_size[k] == '0) begin
            if (addr != sym_start[k]) continue;
         end else begin
            top = sym_start[k] + sym_size[k];
            if (!(addr < top)) continue;
         end
         if (!have || sym_start[k] > sym_start[best]) begin
            have = 1'b1;
            best = k;
         end
      end
      if (have) begin
         r.found = 1'b1;
         r.func_base = sym_start[best];
         r.func_name_off = sym_name[best];
         r.match_index = best[ENTRY_IDX_W-1:0];
      end
      return r;
   endfunction

   function automatic aflr_rsp_type hit(input logic [31:0] start, input logic [31:0] name,
                                        input int idx);
      aflr_rsp_type r;
      r.found = 1'b1;
      r.func_base = start;
      r.func_name_off = name;
      r.match_index = idx[ENTRY_IDX_W-1:0];
      return r;
   endfunction

   function automatic aflr_req_type random_item();
      aflr_req_type r;
      r.command = 1'($urandom);
      r.entry_index = ENTRY_IDX_W'($urandom);
      r.sym_base = $urandom;
      r.symbol_size = $urandom;
      r.symbol_type = TYPE_W'($urandom);
      r.name_off = $urandom;
      r.name_is_empty = 1'($urandom);
      r.query_address = $urandom;
      return r;
   endfunction

   // Mostly clean function entries near the phase base, some with one defect, some noise.
   function automatic aflr_req_type make_entry(input int slot);
      aflr_req_type r;
      int           sel;
      r = random_item();
      r.command = CMD_WRITE;
      r.entry_index = slot[ENTRY_IDX_W-1:0];
      sel = $urandom_range(0, 99);
      if (sel < 90) begin
         r.symbol_type = FUNC_TYPE;
         r.name_is_empty = 1'b0;
         r.name_off = (gen_strtab == '0) ? $urandom : $urandom_range(gen_strtab - 1, 0);
         r.sym_base = gen_base + ($urandom & 32'h3FF);
         r.symbol_size = ($urandom_range(0, 5) == 0) ? '0 : $urandom_range(1, 'h200);
         if (sel >= 70) begin
            case ($urandom_range(0, 3))
               0: r.symbol_type = FUNC_TYPE ^ TYPE_W'($urandom_range(1, 15));
               1: r.name_off = gen_strtab + ($urandom & 32'hFF);
               2: r.name_is_empty = 1'b1;
               default: r.symbol_size = 32'hFFFF_FFFF - $urandom_range(0, 'h3FF);
            endcase
         end
      end
      return r;
   endfunction

   // Aim most lookups at the edges and inside of entries in scan range.
   function automatic aflr_req_type make_lookup(input int n);
      aflr_req_type      r;
      int                sel;
      int                k;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] z;
      r = random_item();
      r.command = CMD_LOOKUP;
      sel = $urandom_range(0, 99);
      if (n > 0 && sel < 60) begin
         k = $urandom_range(0, n - 1);
         s = sym_start[k];
         z = sym_size[k];
         case ($urandom_range(0, 4))
            0: r.query_address = s;
            1: r.query_address = s + z - 1;
            2: r.query_address = s + z;
            3: r.query_address = s + ($urandom & 32'h3FF);
            default: r.query_address = s - 1;
         endcase
      end else if (sel < 85) begin
         r.query_address = gen_base + $urandom_range(0, 'h5FF);
      end
      return r;
   endfunction

   task automatic send_item(input aflr_req_type r, input bit typed, input aflr_rsp_type want);
      int slot;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.command == CMD_WRITE) begin
         slot = int'(r.entry_index);
         sym_start[slot] = r.sym_base;
         sym_size[slot] = r.symbol_size;
         sym_type[slot] = r.symbol_type;
         sym_name[slot] = r.name_off;
         sym_empty[slot] = r.name_is_empty;
         sym_written[slot] = 1'b1;
         n_writes++;
      end else begin
         pending_results.push_back(typed ? want : resolve_address(r.query_address));
         n_lookups++;
      end
   endtask

   task automatic pause_sender();
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every pending result, then let the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] count_word, input logic [31:0] strtab);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ENTRY_COUNT;
      csr_data <= count_word;
      @(posedge clock);
      cfg_count = count_word[COUNT_REG_W-1:0];
      csr_index <= CSR_STR_TABLE_LEN;
      csr_data <= strtab;
      @(posedge clock);
      cfg_strtab = strtab;
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic run_phase(input logic [31:0] count_word, input logic [31:0] strtab,
                            input logic [31:0] base, input int n_items, input int write_pct,
                            input int hold, input bit drain_mid);
      int n;
      int slot;
      n = int'(count_word[COUNT_REG_W-1:0]);
      if (n > MAX_SYMBOLS) n = MAX_SYMBOLS;
      gen_base = base;
      gen_strtab = strtab;
      // fill every slot in scan range that was never written
      for (int k = 0; k < n; k++) begin
         if (!sym_written[k]) begin
            pause_sender();
            send_item(make_entry(k), 1'b0, '0);
         end
      end
      settle();
      program_regs(count_word, strtab);
      hold_rsp = hold;
      for (int i = 0; i < n_items; i++) begin
         if (drain_mid && i == n_items / 2) settle();
         pause_sender();
         if ($urandom_range(0, 99) < write_pct) begin
            slot = (n > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1)
                                                        : $urandom_range(0, MAX_SYMBOLS - 1);
            send_item(make_entry(slot), 1'b0, '0);
         end else begin
            send_item(make_lookup(n), 1'b0, '0);
         end
      end
      settle();
   endtask

   function automatic void add_write(input int slot, input logic [31:0] start,
                                     input logic [31:0] size, input logic [3:0] typ,
                                     input logic [31:0] name, input logic empty);
      plan_row_type row;
      row = '{ROW_ITEM, random_item(), 1'b0, '0, '0, '0};
      row.req.command = CMD_WRITE;
      row.req.entry_index = slot[ENTRY_IDX_W-1:0];
      row.req.sym_base = start;
      row.req.symbol_size = size;
      row.req.symbol_type = typ;
      row.req.name_off = name;
      row.req.name_is_empty = empty;
      script.push_back(row);
   endfunction

   function automatic void add_lookup(input logic [31:0] addr, input bit typed,
                                      input aflr_rsp_type want);
      plan_row_type row;
      row = '{ROW_ITEM, random_item(), typed, want, '0, '0};
      row.req.command = CMD_LOOKUP;
      row.req.query_address = addr;
      script.push_back(row);
   endfunction

   function automatic void add_regs(input logic [31:0] count_word, input logic [31:0] strtab);
      plan_row_type row;
      row = '{ROW_CSR, '0, 1'b0, '0, count_word, strtab};
      script.push_back(row);
   endfunction

   // receiver: random stall bursts, plus one long hold when asked
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp > 0) begin
            n = hold_rsp;
            hold_rsp = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      aflr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_error($sformatf("result with no lookup pending: found=%0b start=%h",
                                 rsp_data.found, rsp_data.func_base));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.found !== want.found)
               note_error($sformatf("found %b, want %b", rsp_data.found, want.found));
            if (rsp_data.func_base !== want.func_base)
               note_error($sformatf("func_base %h, want %h",
                                    rsp_data.func_base, want.func_base));
            if (rsp_data.func_name_off !== want.func_name_off)
               note_error($sformatf("func_name_off %h, want %h",
                                    rsp_data.func_name_off, want.func_name_off));
            if (rsp_data.match_index !== want.match_index)
               note_error($sformatf("match_index %0d, want %0d",
                                    rsp_data.match_index, want.match_index));
            if (want.found) n_hits++;
            else n_misses++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      // registers at reset value: nothing can match
      add_regs(32'd0, 32'd0);
      add_lookup(32'h0000_0000, 1'b1, '0);
      add_lookup(32'hFFFF_FFFF, 1'b1, '0);
      add_write(0, 32'h0000_1000, 32'h100, FUNC_TYPE, 32'd5, 1'b0);
      add_write(1, 32'h0000_1000, 32'h10, FUNC_TYPE, 32'd6, 1'b0);      // same start as slot 0
      add_write(2, 32'h0000_1080, 32'h0, FUNC_TYPE, 32'd7, 1'b0);       // single point
      add_write(3, 32'h0000_1040, 32'h20, 4'd1, 32'd1, 1'b0);           // not a function
      add_write(4, 32'h0000_1050, 32'h40, FUNC_TYPE, 32'd200, 1'b0);    // name past string table
      add_write(5, 32'h0000_1060, 32'h40, FUNC_TYPE, 32'd8, 1'b1);      // empty name
      add_write(6, 32'hFFFF_FFF0, 32'h20, FUNC_TYPE, 32'd9, 1'b0);      // end wraps past 2^32
      add_write(7, 32'hFFFF_FF00, 32'hFF, FUNC_TYPE, 32'd99, 1'b0);
      add_write(1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1'b1);
      add_regs(32'd8, 32'd100);
      add_lookup(32'h0000_1000, 1'b1, hit(32'h1000, 32'd5, 0));
      add_lookup(32'h0000_0FFF, 1'b1, '0);
      add_lookup(32'h0000_1080, 1'b1, hit(32'h1080, 32'd7, 2));
      add_lookup(32'h0000_1081, 1'b0, '0);
      add_lookup(32'h0000_1045, 1'b0, '0);
      add_lookup(32'h0000_1055, 1'b0, '0);
      add_lookup(32'h0000_1065, 1'b0, '0);
      add_lookup(32'h0000_100F, 1'b0, '0);
      add_lookup(32'hFFFF_FFF5, 1'b1, hit(32'hFFFF_FF00, 32'd99, 7));
      add_lookup(32'hFFFF_FFFF, 1'b1, '0);
      add_lookup(32'h0000_1100, 1'b1, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            settle();
            program_regs(script[i].count_word, script[i].strtab);
         end else begin
            pause_sender();
            send_item(script[i].req, script[i].typed, script[i].want);
         end
      end
      settle();

      run_phase(32'd1, 32'hFFFF_FFFF, $urandom, 40, 35, 0, 1'b0);
      run_phase(32'd16, $urandom, 32'h0000_0000, 70, 35, 200, 1'b0);
      run_phase(32'd40, 32'd1000, $urandom, 70, 35, 0, 1'b1);
      run_phase(32'hFFFF_F805, 32'd0, $urandom, 40, 35, 0, 1'b0);  // upper bits dropped
      run_phase(32'd64, $urandom_range(1, 64), $urandom, 70, 35, 0, 1'b0);
      run_phase(32'd24, 32'hFFFF_FFFF, 32'hFFFF_FC00, 70, 35, 0, 1'b0);
      run_phase(32'd0, $urandom, $urandom, 20, 35, 0, 1'b0);
      run_phase(32'd100, 32'hFFFF_FFFF, $urandom, 50, 35, 0, 1'b0);

      // no idling on either side
      sender_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_phase(32'd100, $urandom | 32'h8000_0000, $urandom, 40, 20, 0, 1'b0);

      $display("Covered %0d write items and %0d lookups (%0d hits, %0d misses)",
               n_writes, n_lookups, n_hits, n_misses);
      $display("over %0d register settings, entry counts 0 to 100, upper count bits dropped once",
               n_settings);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
